[rtl/core/sorted_sparse_cell_table_assert.svh]
// Assertion macros for the sorted sparse cell table.
`ifndef SORTED_SPARSE_CELL_TABLE_ASSERT_SVH
`define SORTED_SPARSE_CELL_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
`define SSCT_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define SSCT_ASSERT_NOW(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("state check failed");
`else
`define SSCT_ASSERT(label, clk, rst_n, prop)
`define SSCT_ASSERT_NOW(label, clk, rst_n, prop)
`endif
`endif

[rtl/core/ssct_pkg.sv]
// ----------------------------------------------------------------------------
// ssct_pkg
// Types and constants shared by the sorted sparse cell table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package ssct_pkg;
  localparam int Capacity = 64;
  localparam int GridDim  = 1024;
  localparam int IdxW     = $clog2(Capacity);
  localparam int CntW     = $clog2(Capacity + 1);
  localparam int CoordW   = $clog2(GridDim);
  localparam int KeyW     = 2 * CoordW;

  typedef enum logic [2:0] {
    CMD_INSERT = 3'd0, CMD_APPEND = 3'd1, CMD_FILL = 3'd2,
    CMD_REMOVE = 3'd3, CMD_LOOKUP = 3'd4, CMD_RANK = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_OCCUPIED = 3'd1, ST_NOT_FOUND = 3'd2,
    ST_FULL = 3'd3, ST_OUT_OF_GRID = 3'd4
  } status_e;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [9:0]         row_in;
    logic [9:0]         col_in;
    logic signed [31:0] value_in;
    logic [5:0]         rank_in;
  } in_word_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [9:0]         row_out;
    logic [9:0]         col_out;
    logic signed [31:0] value_out;
    logic [6:0]         cell_count;
  } out_word_t;

  typedef struct packed {
    logic [CoordW-1:0] row;
    logic [CoordW-1:0] col;
    logic [31:0]       value;
  } entry_t;
endpackage

[rtl/core/sorted_sparse_cell_table.sv]
// ----------------------------------------------------------------------------
// sorted_sparse_cell_table
// Bounded table of sparse matrix cells kept sorted by (row, column).
// ----------------------------------------------------------------------------
// Channel  Direction  Signals
// in       input      in_valid_i, in_ready_o, in_data_i
// out      output     out_valid_o, out_ready_i, out_data_o
// One word is handled at a time. Insert, fill, remove and lookup scan the
// table one entry per cycle to find their position; append and rank read one
// entry. Insert, fill and remove then shift entries one at a time, each read
// in S_SHRD and written in S_SHWR. Reset leaves the table empty; no clearing
// pass is needed. A stalled result holds the table idle until it is taken.
`timescale 1ns / 1ps
`include "sorted_sparse_cell_table_assert.svh"
module sorted_sparse_cell_table (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ssct_pkg::in_word_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ssct_pkg::out_word_t out_data_o
);
  import ssct_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SCAN  = 7'b0000010,
    S_DEC   = 7'b0000100,
    S_SHRD  = 7'b0001000,
    S_SHWR  = 7'b0010000,
    S_FIN   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  entry_t mem [Capacity];
  entry_t rd_q;
  logic [IdxW-1:0] raddr, waddr;
  logic            we;
  entry_t          wdata;

  in_word_t  req_q;
  out_word_t res_q, res_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] idx_q, idx_d;   // entry whose read data arrives now
  logic [KeyW:0]   fill_q, fill_d; // fill candidate key
  logic [CntW-1:0] pos_q, pos_d;
  logic            hit_q, hit_d;
  entry_t          hold_q, hold_d;
  logic [CntW-1:0] sh_q, sh_d;

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[raddr];
  end

  logic [KeyW-1:0] ek;
  logic            tgt_oog;
  logic [CoordW-1:0] tr, tc;
  logic            app_oog;
  logic [CoordW:0] lastc;

  assign ek = {rd_q.row, rd_q.col};

  always_comb begin
    lastc = {1'b0, hold_q.col} + 1'b1;
    app_oog = 1'b0;
    tr = req_q.row_in;
    tc = req_q.col_in;
    case (req_q.cmd)
      CMD_APPEND: begin
        if (cnt_q == '0) begin
          tr = '0; tc = '0;
        end else begin
          tr = hold_q.row; tc = lastc[CoordW-1:0]; app_oog = lastc[CoordW];
        end
      end
      CMD_FILL: begin
        tr = fill_q[KeyW-1:CoordW]; tc = fill_q[CoordW-1:0];
      end
      default: ;
    endcase
    tgt_oog = app_oog || (req_q.cmd == CMD_FILL && fill_q[KeyW]);
  end

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q; idx_d = idx_q; fill_d = fill_q; pos_d = pos_q; hit_d = hit_q;
    hold_d = hold_q; sh_d = sh_q; res_d = res_q;
    raddr = idx_q[IdxW-1:0];
    waddr = '0; we = 1'b0; wdata = hold_q;
    case (state_q)
      S_IDLE: begin
        idx_d = '0; fill_d = '0; pos_d = cnt_q; hit_d = 1'b0;
        raddr = '0;
        if (in_valid_i) begin
          if (in_data_i.cmd == CMD_APPEND && cnt_q != '0) begin
            raddr = IdxW'(cnt_q - 1'b1);
            idx_d = cnt_q - 1'b1;
          end else if (in_data_i.cmd == CMD_RANK) begin
            raddr = in_data_i.rank_in[IdxW-1:0];
          end
          state_d = (in_data_i.cmd == CMD_APPEND || in_data_i.cmd == CMD_RANK) ?
                    S_DEC : S_SCAN;
        end
      end
      S_SCAN: begin
        // Read data for entry idx_q is valid here; next entry is requested.
        raddr = IdxW'(idx_q + 1'b1);
        if (idx_q >= cnt_q) begin
          state_d = S_DEC;
        end else if (req_q.cmd == CMD_FILL) begin
          if ({1'b0, ek} == fill_q) begin
            fill_d = fill_q + 1'b1; idx_d = idx_q + 1'b1;
          end else state_d = S_DEC;
        end else if (ek >= {req_q.row_in, req_q.col_in}) begin
          pos_d = idx_q; hit_d = ek == {req_q.row_in, req_q.col_in};
          hold_d = rd_q; state_d = S_DEC;
        end else idx_d = idx_q + 1'b1;
      end
      S_DEC: begin
        res_d = '0;
        res_d.cell_count = 7'(cnt_q);
        if (req_q.cmd == CMD_APPEND) hold_d = rd_q;
        state_d = S_FIN;
        case (req_q.cmd)
          CMD_RANK: begin
            if ({1'b0, req_q.rank_in} < 7'(cnt_q)) begin
              res_d.row_out = rd_q.row; res_d.col_out = rd_q.col;
              res_d.value_out = rd_q.value;
            end else res_d.status = ST_NOT_FOUND;
            state_d = S_OUT;
          end
          CMD_APPEND, CMD_FILL: begin
            // Fill takes the scan index as its position; both then follow the insert path.
            if (req_q.cmd == CMD_FILL) begin
              pos_d = idx_q; hit_d = 1'b0;
            end
            state_d = S_FIN;
          end
          default: ;
        endcase
      end
      S_FIN: begin
        res_d.cell_count = 7'(cnt_q);
        case (req_q.cmd)
          CMD_INSERT, CMD_APPEND, CMD_FILL: begin
            if (tgt_oog) begin
              res_d.status = ST_OUT_OF_GRID; state_d = S_OUT;
            end else if (hit_q && req_q.cmd == CMD_INSERT) begin
              res_d.status = ST_OCCUPIED; res_d.row_out = tr; res_d.col_out = tc;
              res_d.value_out = hold_q.value; state_d = S_OUT;
            end else if (cnt_q >= CntW'(Capacity)) begin
              res_d.status = ST_FULL; state_d = S_OUT;
            end else begin
              res_d.row_out = tr; res_d.col_out = tc;
              res_d.value_out = req_q.value_in;
              if (req_q.cmd == CMD_APPEND) pos_d = cnt_q;
              hold_d.row = tr; hold_d.col = tc; hold_d.value = req_q.value_in;
              sh_d = cnt_q;
              state_d = S_SHRD;
            end
          end
          CMD_REMOVE, CMD_LOOKUP: begin
            res_d.row_out = req_q.row_in; res_d.col_out = req_q.col_in;
            if (!hit_q) begin
              res_d.status = ST_NOT_FOUND; state_d = S_OUT;
            end else begin
              res_d.value_out = hold_q.value;
              if (req_q.cmd == CMD_REMOVE) begin
                sh_d = pos_q; state_d = S_SHRD;
              end else state_d = S_OUT;
            end
          end
          default: state_d = S_OUT;
        endcase
      end
      S_SHRD: begin
        if (req_q.cmd == CMD_REMOVE) begin
          if (sh_q + 1'b1 >= cnt_q) begin
            cnt_d = cnt_q - 1'b1; res_d.cell_count = 7'(cnt_d); state_d = S_OUT;
          end else begin
            raddr = IdxW'(sh_q + 1'b1); state_d = S_SHWR;
          end
        end else if (sh_q == pos_q) begin
          we = 1'b1; waddr = pos_q[IdxW-1:0]; wdata = hold_q;
          cnt_d = cnt_q + 1'b1; res_d.cell_count = 7'(cnt_d); state_d = S_OUT;
        end else begin
          raddr = IdxW'(sh_q - 1'b1); state_d = S_SHWR;
        end
      end
      S_SHWR: begin
        we = 1'b1; waddr = sh_q[IdxW-1:0]; wdata = rd_q;
        sh_d = (req_q.cmd == CMD_REMOVE) ? sh_q + 1'b1 : sh_q - 1'b1;
        state_d = S_SHRD;
      end
      S_OUT: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Append lands at the end; fill uses scan index as its position.
  // The first scan cycle must see read data for entry 0.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) req_q <= in_data_i;
    idx_q <= idx_d; fill_q <= fill_d; pos_q <= pos_d; hit_q <= hit_d;
    hold_q <= hold_d; sh_q <= sh_d; res_q <= res_d;
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = state_q == S_OUT;
  assign out_data_o  = res_q;

  `SSCT_ASSERT(a_count_range, clk_i, rst_ni, cnt_q <= CntW'(Capacity))
  `SSCT_ASSERT(a_one_hot, clk_i, rst_ni, $onehot(state_q))
  `SSCT_ASSERT_NOW(a_out_holds, clk_i, rst_ni,
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
endmodule
